>>> src/cdiv_pkg.sv
// complex divider package: widths, pipeline entry types and the divide step
// no dependencies
`default_nettype none
package cdiv_pkg;
  localparam int DataWidth = 16;
  localparam int FracOut = 16;
  localparam int OutWidth = 32;
  localparam int ProdW = 2 * DataWidth;
  localparam int MagW = 2 * DataWidth;
  localparam int DenW = 2 * DataWidth;
  localparam int DivW = MagW + FracOut + 1;
  localparam int CmpW = DivW + OutWidth;

  typedef struct packed {
    logic valid;
    logic signed [ProdW-1:0] ac;
    logic signed [ProdW-1:0] bd;
    logic signed [ProdW-1:0] bc;
    logic signed [ProdW-1:0] ad;
    logic signed [ProdW-1:0] cc;
    logic signed [ProdW-1:0] dd;
  } prod_t;

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [DivW-1:0] x;
    logic neg;
  } lane_t;

  typedef struct packed {
    logic valid;
    logic dz;
    logic [DenW-1:0] den;
    lane_t re;
    lane_t im;
  } div_t;

  // one restoring step: shift in next dividend bit, quotient bit shifts into x
  function automatic lane_t div_step(lane_t l, logic [DenW-1:0] den);
    lane_t o;
    logic [DenW:0] r2;
    logic [DenW:0] diff;
    r2 = {l.rem, l.x[DivW-1]};
    diff = r2 - {1'b0, den};
    o.neg = l.neg;
    if (!diff[DenW]) begin
      o.rem = diff[DenW-1:0];
      o.x = {l.x[DivW-2:0], 1'b1};
    end else begin
      o.rem = r2[DenW-1:0];
      o.x = {l.x[DivW-2:0], 1'b0};
    end
    return o;
  endfunction
endpackage
`default_nettype wire

>>> src/cdiv_mult.sv
// complex divider front end: products, then numerators, magnitudes and denominator
// depends on cdiv_pkg
`default_nettype none
module cdiv_mult (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic signed [cdiv_pkg::DataWidth-1:0] dividend_re,
  input  wire logic signed [cdiv_pkg::DataWidth-1:0] dividend_im,
  input  wire logic signed [cdiv_pkg::DataWidth-1:0] divisor_re,
  input  wire logic signed [cdiv_pkg::DataWidth-1:0] divisor_im,
  output cdiv_pkg::div_t q
);
  cdiv_pkg::prod_t p;
  cdiv_pkg::div_t q_next;
  logic signed [cdiv_pkg::ProdW:0] nre;
  logic signed [cdiv_pkg::ProdW:0] nim;
  logic [cdiv_pkg::ProdW:0] mre;
  logic [cdiv_pkg::ProdW:0] mim;

  always_ff @(posedge clk) begin
    if (en) begin
      p.ac <= dividend_re * divisor_re;
      p.bd <= dividend_im * divisor_im;
      p.bc <= dividend_im * divisor_re;
      p.ad <= dividend_re * divisor_im;
      p.cc <= divisor_re * divisor_re;
      p.dd <= divisor_im * divisor_im;
    end
    if (rst) p.valid <= 1'b0;
    else if (en) p.valid <= in_valid;
  end

  always_comb begin
    nre = {p.ac[cdiv_pkg::ProdW-1], p.ac} + {p.bd[cdiv_pkg::ProdW-1], p.bd};
    nim = {p.bc[cdiv_pkg::ProdW-1], p.bc} - {p.ad[cdiv_pkg::ProdW-1], p.ad};
    mre = nre[cdiv_pkg::ProdW] ? -nre : nre;
    mim = nim[cdiv_pkg::ProdW] ? -nim : nim;
    q_next.valid = p.valid;
    q_next.den = p.cc[cdiv_pkg::DenW-1:0] + p.dd[cdiv_pkg::DenW-1:0];
    q_next.dz = (q_next.den == '0);
    q_next.re.rem = '0;
    q_next.re.neg = nre[cdiv_pkg::ProdW];
    q_next.re.x = {mre[cdiv_pkg::MagW-1:0], {(cdiv_pkg::FracOut+1){1'b0}}};
    q_next.im.rem = '0;
    q_next.im.neg = nim[cdiv_pkg::ProdW];
    q_next.im.x = {mim[cdiv_pkg::MagW-1:0], {(cdiv_pkg::FracOut+1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.dz <= q_next.dz;
      q.den <= q_next.den;
      q.re <= q_next.re;
      q.im <= q_next.im;
    end
    if (rst) q.valid <= 1'b0;
    else if (en) q.valid <= q_next.valid;
  end
endmodule
`default_nettype wire

>>> src/cdiv_step.sv
// complex divider: one registered restoring division step for both lanes
// depends on cdiv_pkg
`default_nettype none
module cdiv_step (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire cdiv_pkg::div_t d,
  output cdiv_pkg::div_t q
);
  always_ff @(posedge clk) begin
    if (en) begin
      q.dz <= d.dz;
      q.den <= d.den;
      q.re <= cdiv_pkg::div_step(d.re, d.den);
      q.im <= cdiv_pkg::div_step(d.im, d.den);
    end
    if (rst) q.valid <= 1'b0;
    else if (en) q.valid <= d.valid;
  end
endmodule
`default_nettype wire

>>> src/cdiv_round.sv
// complex divider back end: rounding, sign, saturation and output register
// depends on cdiv_pkg
`default_nettype none
module cdiv_round (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire cdiv_pkg::div_t d,
  output logic out_valid,
  output logic signed [cdiv_pkg::OutWidth-1:0] quotient_re,
  output logic signed [cdiv_pkg::OutWidth-1:0] quotient_im,
  output logic divide_by_zero,
  output logic saturated
);
  localparam logic [cdiv_pkg::CmpW-1:0] PosLim =
    (cdiv_pkg::CmpW'(1) << (cdiv_pkg::OutWidth - 1)) - cdiv_pkg::CmpW'(1);
  localparam logic [cdiv_pkg::CmpW-1:0] NegLim =
    cdiv_pkg::CmpW'(1) << (cdiv_pkg::OutWidth - 1);

  logic [cdiv_pkg::OutWidth-1:0] re_next;
  logic [cdiv_pkg::OutWidth-1:0] im_next;
  logic sre;
  logic sim;

  function automatic logic [cdiv_pkg::OutWidth:0] fin(cdiv_pkg::lane_t l);
    logic [cdiv_pkg::DivW:0] xs;
    logic [cdiv_pkg::CmpW-1:0] v;
    logic [cdiv_pkg::CmpW-1:0] lim;
    logic s;
    xs = {1'b0, l.x} + {{cdiv_pkg::DivW{1'b0}}, 1'b1};
    v = {{cdiv_pkg::OutWidth{1'b0}}, xs[cdiv_pkg::DivW:1]};
    lim = l.neg ? NegLim : PosLim;
    s = v > lim;
    if (s) v = lim;
    if (l.neg) v = -v;
    return {s, v[cdiv_pkg::OutWidth-1:0]};
  endfunction

  always_comb begin
    {sre, re_next} = fin(d.re);
    {sim, im_next} = fin(d.im);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient_re <= d.dz ? '0 : re_next;
      quotient_im <= d.dz ? '0 : im_next;
      divide_by_zero <= d.dz;
      saturated <= !d.dz && (sre || sim);
    end
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= d.valid;
  end
endmodule
`default_nettype wire

>>> src/complex_divider_top.sv
// complex divider top level: front end, chain of division steps, back end
// depends on cdiv_pkg, cdiv_mult, cdiv_step, cdiv_round
//
// usage
//   input channel in_valid/in_ready carries dividend and divisor, signed Q1.15
//   output channel out_valid/out_ready carries the Q16.16 quotient and flags
//   one request accepted per cycle while the receiver takes results
//   the result passes through two multiply and add stages, one restoring step
//   per quotient bit and one rounding stage
//   throughput: one result per cycle unless a waiting result is stalled
//   by out_ready, set by the fully pipelined step chain
//   zero divisor gives zero parts with divide_by_zero set
//   reset clears all valid bits; the pipe is empty after reset
//   when out_ready is low with a result waiting, the whole pipe holds and
//   in_ready drops; nothing is lost or repeated
`default_nettype none
module complex_divider_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [cdiv_pkg::DataWidth-1:0] dividend_re,
  input  wire logic signed [cdiv_pkg::DataWidth-1:0] dividend_im,
  input  wire logic signed [cdiv_pkg::DataWidth-1:0] divisor_re,
  input  wire logic signed [cdiv_pkg::DataWidth-1:0] divisor_im,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [cdiv_pkg::OutWidth-1:0] quotient_re,
  output logic signed [cdiv_pkg::OutWidth-1:0] quotient_im,
  output logic divide_by_zero,
  output logic saturated
);
  logic en;
  cdiv_pkg::div_t pipe [cdiv_pkg::DivW+1];

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  cdiv_mult u_mult (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .dividend_re(dividend_re), .dividend_im(dividend_im),
    .divisor_re(divisor_re), .divisor_im(divisor_im),
    .q(pipe[0])
  );

  for (genvar i = 0; i < cdiv_pkg::DivW; i++) begin : g_step
    cdiv_step u_step (
      .clk(clk), .rst(rst), .en(en), .d(pipe[i]), .q(pipe[i+1])
    );
  end

  cdiv_round u_round (
    .clk(clk), .rst(rst), .en(en), .d(pipe[cdiv_pkg::DivW]),
    .out_valid(out_valid), .quotient_re(quotient_re), .quotient_im(quotient_im),
    .divide_by_zero(divide_by_zero), .saturated(saturated)
  );

`ifndef NO_ASSERTIONS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> quotient_re == '0 && quotient_im == '0 && !saturated)
    else $error("zero divisor result not cleared");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient_re) && $stable(quotient_im))
    else $error("stalled result changed");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pipe[cdiv_pkg::DivW].valid))
    else $error("pipe moved during stall");
`endif
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// testbench for complex_divider_top: random and directed complex divisions checked
// against an in-bench predictor of the rounded, saturated Q16.16 quotient
// depends on cdiv_pkg and complex_divider_top
`timescale 1ns / 1ps
module tb_top;
  localparam int DW = cdiv_pkg::DataWidth;
  localparam int OW = cdiv_pkg::OutWidth;
  localparam int FRAC = cdiv_pkg::FracOut;

  typedef struct {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] d;
  } cdiv_req_t;

  typedef struct {
    logic signed [OW-1:0] re;
    logic signed [OW-1:0] im;
    logic dz;
    logic sat;
  } quot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DW-1:0] dividend_re = '0;
  logic signed [DW-1:0] dividend_im = '0;
  logic signed [DW-1:0] divisor_re = '0;
  logic signed [DW-1:0] divisor_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OW-1:0] quotient_re;
  logic signed [OW-1:0] quotient_im;
  logic divide_by_zero;
  logic saturated;

  cdiv_req_t req_q[$];
  quot_t quot_q[$];
  cdiv_req_t cur_req;
  int n_sent = 0;
  int n_fail = 0;

  complex_divider_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .dividend_re(dividend_re), .dividend_im(dividend_im),
    .divisor_re(divisor_re), .divisor_im(divisor_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .quotient_re(quotient_re), .quotient_im(quotient_im),
    .divide_by_zero(divide_by_zero), .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // {saturated, 32-bit pattern}
  function automatic logic [OW:0] divide_part(longint num, longint den);
    longint mag, lim, val, rr;
    bit neg, sat;
    neg = num < 0;
    mag = neg ? -num : num;
    lim = neg ? 64'sh80000000 : 64'sh7fffffff;
    val = (mag <<< FRAC) / den;
    rr = (mag <<< FRAC) % den;
    if (2 * rr >= den) val = val + 1;
    sat = 1'b0;
    if (val > lim) begin
      val = lim;
      sat = 1'b1;
    end
    if (neg) val = -val;
    return {sat, val[OW-1:0]};
  endfunction

  function automatic quot_t predict_quot(cdiv_req_t r);
    quot_t q;
    longint a, b, c, d, den;
    logic [OW:0] pr, pi;
    a = r.a;
    b = r.b;
    c = r.c;
    d = r.d;
    den = c * c + d * d;
    if (den == 0) begin
      q.re = '0;
      q.im = '0;
      q.dz = 1'b1;
      q.sat = 1'b0;
    end else begin
      pr = divide_part(a * c + b * d, den);
      pi = divide_part(b * c - a * d, den);
      q.re = pr[OW-1:0];
      q.im = pi[OW-1:0];
      q.dz = 1'b0;
      q.sat = pr[OW] | pi[OW];
    end
    return q;
  endfunction

  function automatic int send_idle_pct(int n);
    return (n < 500) ? 15 : (n < 1000) ? 59 : 0;
  endfunction

  function automatic int recv_idle_pct(int n);
    return (n < 500) ? 59 : (n < 1000) ? 15 : 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        quot_q.push_back(predict_quot(cur_req));
        n_sent <= n_sent + 1;
      end
      // drain the pipe completely at each phase change
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct(n_sent) &&
          !((n_sent == 500 || n_sent == 1000) && quot_q.size() != 0) &&
          !(in_valid && (n_sent + 1 == 500 || n_sent + 1 == 1000))) begin
        cur_req = req_q.pop_front();
        in_valid <= 1'b1;
        dividend_re <= cur_req.a;
        dividend_im <= cur_req.b;
        divisor_re <= cur_req.c;
        divisor_im <= cur_req.d;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quot_t q;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (quot_q.size() == 0) begin
          $error("result with no request pending");
          n_fail = n_fail + 1;
        end else begin
          q = quot_q.pop_front();
          if (quotient_re !== q.re) begin
            $error("quotient_re expected %h actual %h", q.re, quotient_re);
            n_fail = n_fail + 1;
          end
          if (quotient_im !== q.im) begin
            $error("quotient_im expected %h actual %h", q.im, quotient_im);
            n_fail = n_fail + 1;
          end
          if (divide_by_zero !== q.dz) begin
            $error("divide_by_zero expected %b actual %b", q.dz, divide_by_zero);
            n_fail = n_fail + 1;
          end
          if (saturated !== q.sat) begin
            $error("saturated expected %b actual %b", q.sat, saturated);
            n_fail = n_fail + 1;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct(n_sent));
    end
  end

  task automatic add_req(int a, int b, int c, int d);
    cdiv_req_t r;
    r.a = DW'(a);
    r.b = DW'(b);
    r.c = DW'(c);
    r.d = DW'(d);
    req_q.push_back(r);
  endtask

  function automatic int rnd_part(int bits);
    int v;
    v = $urandom_range((1 << bits) - 1);
    return v - (1 << (bits - 1));
  endfunction

  initial begin
    int sel;
    add_req(32767, 32767, 32767, 32767);
    add_req(-32768, -32768, -32768, -32768);
    add_req(32767, -32768, -32768, 32767);
    add_req(1234, -5678, 0, 0);
    add_req(-32768, 32767, 0, 0);
    add_req(32767, 32767, 1, 0);
    add_req(-32768, -32768, 1, 0);
    add_req(-32768, 0, 1, 0);
    add_req(32767, 0, 1, 0);
    add_req(0, -32768, 0, -1);
    add_req(-32768, 0, -1, 0);
    add_req(32767, -32768, 0, 1);
    add_req(1, 0, 3, 0);
    add_req(1, 0, 2, 0);
    add_req(-1, 0, 2, 0);
    add_req(1, 1, 32767, -32768);
    add_req(0, 0, 5, 7);
    add_req(100, 200, 3, 4);
    add_req(-32768, -32768, 1, 1);
    add_req(32767, 32767, -1, -1);
    for (int i = 0; i < 1500; i++) begin
      sel = $urandom_range(9);
      case (sel)
        0: add_req(rnd_part(16), rnd_part(16), 0, 0);
        1, 2: add_req(rnd_part(16), rnd_part(16), rnd_part(4), rnd_part(4));
        3: add_req(rnd_part(16), rnd_part(16), rnd_part(16), 0);
        4: add_req(rnd_part(16), rnd_part(16), 0, rnd_part(16));
        default: add_req(rnd_part(16), rnd_part(16), rnd_part(16), rnd_part(16));
      endcase
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (quot_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> filelist.f
src/cdiv_pkg.sv
src/cdiv_mult.sv
src/cdiv_step.sv
src/cdiv_round.sv
src/complex_divider_top.sv
sim/tb_top.sv
